// File: hdl/priority_task_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// priority_task_scheduler_top_defines
// Assertion macros used by the scheduler engine.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PTS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define PTS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types, codes and defaults shared by the priority task scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

   localparam int PRIORITY_LEVELS_DEF = 8;
   localparam int TASK_SLOTS_DEF      = 16;
   localparam int TICK_WIDTH_DEF      = 32;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [2:0] ACT_ADD_READY = 3'd0;
   localparam logic [2:0] ACT_REM_READY = 3'd1;
   localparam logic [2:0] ACT_ADD_DELAY = 3'd2;
   localparam logic [2:0] ACT_REM_DELAY = 3'd3;
   localparam logic [2:0] ACT_TICK      = 3'd4;
   localparam logic [2:0] ACT_QUERY     = 3'd5;

   localparam logic [1:0] WHERE_NONE    = 2'd0;
   localparam logic [1:0] WHERE_READY   = 2'd1;
   localparam logic [1:0] WHERE_DELAYED = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  task_id;
      logic [2:0]  priority_req;
      logic [31:0] wait_ticks;
      logic [31:0] tick_now;
      logic        current_valid;
      logic [3:0]  run_task;
      logic [2:0]  current_priority;
   } req_type;

   typedef struct packed {
      logic       next_valid;
      logic [3:0] pick_task;
      logic [2:0] next_priority;
      logic       preempt;
      logic [7:0] ready_mask;
      logic [4:0] ready_num;
      logic [4:0] sleep_num;
      logic [4:0] woken_count;
      logic       status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_ADD_READY,
      OP_REM_READY,
      OP_ADD_DELAY,
      OP_REM_DELAY,
      OP_TICK,
      OP_QUERY,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        args_ok;
      logic [3:0]  task_id;
      logic [2:0]  prio;
      logic [32:0] wake_sum;
      logic [31:0] tick_now;
      logic        cur_valid;
      logic [3:0]  cur_task;
      logic [2:0]  cur_prio;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RU_WALK,
      ST_SI_WALK,
      ST_SU_WALK,
      ST_TICK,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// File: hdl/pts_front.sv
// ----------------------------------------------------------------------------
// pts_front
// Accepts requests, decodes the action and checks slot and priority range.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_front #(
   parameter int PRIORITY_LEVELS = pts_pkg::PRIORITY_LEVELS_DEF,
   parameter int TASK_SLOTS      = pts_pkg::TASK_SLOTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pts_pkg::req_type req_data,
   output logic                  cmd_valid,
   input  wire logic             cmd_stall,
   output pts_pkg::cmd_type      cmd_data
);

   localparam logic [6:0] SLOTS_L = 7'(TASK_SLOTS);
   localparam logic [5:0] LEVELS_L = 6'(PRIORITY_LEVELS);

   logic             hold_ff, hold_in;
   pts_pkg::cmd_type cmd_ff, cmd_in;
   logic             slot_ok, prio_ok;
   logic             take;

   assign req_stall = hold_ff && cmd_stall;
   assign take      = req_valid && !req_stall;
   assign cmd_valid = hold_ff;
   assign cmd_data  = cmd_ff;

   assign slot_ok = {3'b000, req_data.task_id} < SLOTS_L;
   assign prio_ok = {3'b000, req_data.priority_req} < LEVELS_L;

   always_comb begin
      cmd_in           = cmd_ff;
      hold_in          = hold_ff;
      if (hold_ff && !cmd_stall) begin
         hold_in = 1'b0;
      end
      if (take) begin
         hold_in          = 1'b1;
         cmd_in.task_id   = req_data.task_id;
         cmd_in.prio      = req_data.priority_req;
         cmd_in.wake_sum  = {1'b0, req_data.tick_now} + {1'b0, req_data.wait_ticks};
         cmd_in.tick_now  = req_data.tick_now;
         cmd_in.cur_valid = req_data.current_valid;
         cmd_in.cur_task  = req_data.run_task;
         cmd_in.cur_prio  = req_data.current_priority;
         cmd_in.args_ok   = slot_ok;
         case (req_data.action)
            pts_pkg::ACT_ADD_READY: begin
               cmd_in.op      = pts_pkg::OP_ADD_READY;
               cmd_in.args_ok = slot_ok && prio_ok;
            end
            pts_pkg::ACT_REM_READY: cmd_in.op = pts_pkg::OP_REM_READY;
            pts_pkg::ACT_ADD_DELAY: begin
               cmd_in.op      = pts_pkg::OP_ADD_DELAY;
               cmd_in.args_ok = slot_ok && prio_ok;
            end
            pts_pkg::ACT_REM_DELAY: cmd_in.op = pts_pkg::OP_REM_DELAY;
            pts_pkg::ACT_TICK:      cmd_in.op = pts_pkg::OP_TICK;
            pts_pkg::ACT_QUERY:     cmd_in.op = pts_pkg::OP_QUERY;
            default:                cmd_in.op = pts_pkg::OP_BAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

`default_nettype wire

// File: hdl/pts_queue.sv
// ----------------------------------------------------------------------------
// pts_queue
// Short command queue between the decoder and the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire pts_pkg::cmd_type in_cmd,
   output logic                  out_valid,
   input  wire logic             out_pop,
   output pts_pkg::cmd_type      out_cmd
);

   localparam int PTR_W = $clog2(pts_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pts_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(pts_pkg::QUEUE_DEPTH);

   pts_pkg::cmd_type entry_ff [pts_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_stall  = (count_ff == FULL);
   assign push      = in_valid && !in_stall;
   assign out_valid = (count_ff != '0);
   assign pop       = out_pop && out_valid;
   assign out_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

// File: hdl/pts_engine.sv
// ----------------------------------------------------------------------------
// pts_engine
// Ready FIFOs, delayed list and the sequencer that walks them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_task_scheduler_top_defines.svh"

module pts_engine #(
   parameter int PRIORITY_LEVELS = pts_pkg::PRIORITY_LEVELS_DEF,
   parameter int TASK_SLOTS      = pts_pkg::TASK_SLOTS_DEF,
   parameter int TICK_WIDTH      = pts_pkg::TICK_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  q_pop,
   input  wire pts_pkg::cmd_type q_cmd,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pts_pkg::rsp_type      rsp_data
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int LVL_W  = $clog2(PRIORITY_LEVELS);
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

   // task tables
   logic [LVL_W-1:0]      prio_mem  [TASK_SLOTS];
   logic [1:0]            where_ff  [TASK_SLOTS];
   logic [TICK_WIDTH-1:0] wake_mem  [TASK_SLOTS];
   logic [SLOT_W-1:0]     rlink_mem [TASK_SLOTS];
   logic [SLOT_W-1:0]     slink_mem [TASK_SLOTS];
   logic [SLOT_W-1:0]     rhead_mem [PRIORITY_LEVELS];
   logic [SLOT_W-1:0]     rtail_mem [PRIORITY_LEVELS];

   logic [PRIORITY_LEVELS-1:0] level_mask_ff;
   logic [SLOT_W-1:0]          shead_ff;
   logic [CNT_W-1:0]           scount_ff, rtotal_ff;

   pts_pkg::state_type    state_ff, state_in;
   pts_pkg::cmd_type      cmd_ff;
   logic [SLOT_W-1:0]     cur_ff, prev_ff;
   logic                  has_prev_ff;
   logic [CNT_W-1:0]      step_ff, woken_ff;
   logic                  status_ff;
   logic [TICK_WIDTH-1:0] wake_ff;
   logic [LVL_W-1:0]      lvl_ff;
   logic                  rsp_valid_ff;
   pts_pkg::rsp_type      rsp_ff, result;

   logic [SLOT_W-1:0]     t_idx, app_task;
   logic [LVL_W-1:0]      p_arg, app_lvl;
   logic [1:0]            where_t;
   logic [TICK_WIDTH-1:0] now_t, diff_si, diff_tk;
   logic                  exec_ok, si_go, su_go, tk_go, app_do;
   logic                  nv;
   logic [SLOT_W-1:0]     nt;
   logic [LVL_W-1:0]      np;
   logic                  mask_agree, sleep_fits, finish_done;

   assign t_idx   = SLOT_W'(cmd_ff.task_id);
   assign p_arg   = LVL_W'(cmd_ff.prio);
   assign where_t = where_ff[t_idx];
   assign now_t   = TICK_WIDTH'(cmd_ff.tick_now);

   // wrap-safe ordering: a before b when the difference is negative
   assign diff_si = wake_mem[cur_ff] - wake_ff;
   assign si_go   = (step_ff < scount_ff) &&
                    (diff_si[TICK_WIDTH-1] || (wake_mem[cur_ff] == wake_ff));
   assign su_go   = (step_ff < scount_ff) && (cur_ff != t_idx);
   assign diff_tk = now_t - wake_mem[shead_ff];
   assign tk_go   = (scount_ff != '0) && !diff_tk[TICK_WIDTH-1];

   always_comb begin
      case (cmd_ff.op)
         pts_pkg::OP_ADD_READY,
         pts_pkg::OP_ADD_DELAY: exec_ok = cmd_ff.args_ok && (where_t == pts_pkg::WHERE_NONE);
         pts_pkg::OP_REM_READY: exec_ok = cmd_ff.args_ok && (where_t == pts_pkg::WHERE_READY);
         pts_pkg::OP_REM_DELAY: exec_ok = cmd_ff.args_ok && (where_t == pts_pkg::WHERE_DELAYED);
         pts_pkg::OP_TICK,
         pts_pkg::OP_QUERY:     exec_ok = 1'b1;
         default:               exec_ok = 1'b0;
      endcase
   end

   // tail append serves add ready and each woken task
   assign app_do   = ((state_ff == pts_pkg::ST_EXEC) && (cmd_ff.op == pts_pkg::OP_ADD_READY)
                      && exec_ok) || ((state_ff == pts_pkg::ST_TICK) && tk_go);
   assign app_task = (state_ff == pts_pkg::ST_TICK) ? shead_ff : t_idx;
   assign app_lvl  = (state_ff == pts_pkg::ST_TICK) ? prio_mem[shead_ff] : p_arg;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pts_pkg::ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               state_in = pts_pkg::ST_EXEC;
            end
         end
         pts_pkg::ST_EXEC: begin
            state_in = pts_pkg::ST_FINISH;
            if (exec_ok) begin
               case (cmd_ff.op)
                  pts_pkg::OP_REM_READY: state_in = pts_pkg::ST_RU_WALK;
                  pts_pkg::OP_ADD_DELAY: state_in = pts_pkg::ST_SI_WALK;
                  pts_pkg::OP_REM_DELAY: state_in = pts_pkg::ST_SU_WALK;
                  pts_pkg::OP_TICK:      state_in = pts_pkg::ST_TICK;
                  default:               state_in = pts_pkg::ST_FINISH;
               endcase
            end
         end
         pts_pkg::ST_RU_WALK: begin
            if (cur_ff == t_idx) begin
               state_in = pts_pkg::ST_FINISH;
            end
         end
         pts_pkg::ST_SI_WALK: begin
            if (!si_go) begin
               state_in = pts_pkg::ST_FINISH;
            end
         end
         pts_pkg::ST_SU_WALK: begin
            if (!su_go) begin
               state_in = pts_pkg::ST_FINISH;
            end
         end
         pts_pkg::ST_TICK: begin
            if (!tk_go) begin
               state_in = pts_pkg::ST_FINISH;
            end
         end
         pts_pkg::ST_FINISH: state_in = pts_pkg::ST_IDLE;
         default:            state_in = pts_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop = (state_ff == pts_pkg::ST_IDLE) && q_valid && !rsp_valid_ff;
      nv    = 1'b0;
      nt    = '0;
      np    = '0;
      for (int lv = 0; lv < PRIORITY_LEVELS; lv++) begin
         if (level_mask_ff[lv]) begin
            nv = 1'b1;
            nt = rhead_mem[lv];
            np = LVL_W'(lv);
         end
      end
      result.next_valid    = nv;
      result.pick_task     = 4'(nt);
      result.next_priority = 3'(np);
      result.preempt       = nv && cmd_ff.cur_valid && (8'(nt) != 8'(cmd_ff.cur_task)) &&
                             (8'(np) > 8'(cmd_ff.cur_prio));
      result.ready_mask    = 8'(level_mask_ff);
      result.ready_num     = 5'(rtotal_ff);
      result.sleep_num     = 5'(scount_ff);
      result.woken_count   = 5'(woken_ff);
      result.status        = status_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pts_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         level_mask_ff <= '0;
         scount_ff     <= '0;
         rtotal_ff     <= '0;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            where_ff[i] <= pts_pkg::WHERE_NONE;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            pts_pkg::ST_IDLE: begin
               if (q_pop) begin
                  cmd_ff    <= q_cmd;
                  status_ff <= 1'b0;
                  woken_ff  <= '0;
               end
            end
            pts_pkg::ST_EXEC: begin
               wake_ff     <= TICK_WIDTH'(cmd_ff.wake_sum);
               has_prev_ff <= 1'b0;
               step_ff     <= '0;
               case (cmd_ff.op)
                  pts_pkg::OP_ADD_READY: begin
                     if (exec_ok) begin
                        prio_mem[t_idx] <= p_arg;
                     end else begin
                        status_ff <= 1'b1;
                     end
                  end
                  pts_pkg::OP_REM_READY: begin
                     if (exec_ok) begin
                        lvl_ff <= prio_mem[t_idx];
                        cur_ff <= rhead_mem[prio_mem[t_idx]];
                     end else begin
                        status_ff <= 1'b1;
                     end
                  end
                  pts_pkg::OP_ADD_DELAY: begin
                     if (exec_ok) begin
                        prio_mem[t_idx] <= p_arg;
                        wake_mem[t_idx] <= TICK_WIDTH'(cmd_ff.wake_sum);
                        cur_ff          <= shead_ff;
                     end else begin
                        status_ff <= 1'b1;
                     end
                  end
                  pts_pkg::OP_REM_DELAY: begin
                     if (exec_ok) begin
                        cur_ff <= shead_ff;
                     end else begin
                        status_ff <= 1'b1;
                     end
                  end
                  pts_pkg::OP_TICK,
                  pts_pkg::OP_QUERY: begin
                     status_ff <= 1'b0;
                  end
                  default: status_ff <= 1'b1;
               endcase
            end
            pts_pkg::ST_RU_WALK: begin
               if (cur_ff != t_idx) begin
                  prev_ff     <= cur_ff;
                  has_prev_ff <= 1'b1;
                  cur_ff      <= rlink_mem[cur_ff];
               end else begin
                  if (rtail_mem[lvl_ff] == t_idx) begin
                     if (has_prev_ff) begin
                        rtail_mem[lvl_ff] <= prev_ff;
                     end else begin
                        level_mask_ff[lvl_ff] <= 1'b0;
                     end
                  end else if (has_prev_ff) begin
                     rlink_mem[prev_ff] <= rlink_mem[cur_ff];
                  end else begin
                     rhead_mem[lvl_ff] <= rlink_mem[cur_ff];
                  end
                  where_ff[t_idx] <= pts_pkg::WHERE_NONE;
                  rtotal_ff       <= rtotal_ff - 1'b1;
               end
            end
            pts_pkg::ST_SI_WALK: begin
               if (si_go) begin
                  prev_ff <= cur_ff;
                  cur_ff  <= slink_mem[cur_ff];
                  step_ff <= step_ff + 1'b1;
               end else begin
                  slink_mem[t_idx] <= cur_ff;
                  if (step_ff == '0) begin
                     shead_ff <= t_idx;
                  end else begin
                     slink_mem[prev_ff] <= t_idx;
                  end
                  where_ff[t_idx] <= pts_pkg::WHERE_DELAYED;
                  scount_ff       <= scount_ff + 1'b1;
               end
            end
            pts_pkg::ST_SU_WALK: begin
               if (su_go) begin
                  prev_ff <= cur_ff;
                  cur_ff  <= slink_mem[cur_ff];
                  step_ff <= step_ff + 1'b1;
               end else begin
                  if (step_ff == '0) begin
                     shead_ff <= slink_mem[cur_ff];
                  end else begin
                     slink_mem[prev_ff] <= slink_mem[cur_ff];
                  end
                  where_ff[t_idx] <= pts_pkg::WHERE_NONE;
                  scount_ff       <= scount_ff - 1'b1;
               end
            end
            pts_pkg::ST_TICK: begin
               if (tk_go) begin
                  shead_ff  <= slink_mem[shead_ff];
                  scount_ff <= scount_ff - 1'b1;
                  woken_ff  <= woken_ff + 1'b1;
               end
            end
            pts_pkg::ST_FINISH: begin
               rsp_ff       <= result;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
         // append at the tail of the task's level
         if (app_do) begin
            if (!level_mask_ff[app_lvl]) begin
               rhead_mem[app_lvl] <= app_task;
            end else begin
               rlink_mem[rtail_mem[app_lvl]] <= app_task;
            end
            level_mask_ff[app_lvl] <= 1'b1;
            rtail_mem[app_lvl]     <= app_task;
            where_ff[app_task]     <= pts_pkg::WHERE_READY;
            rtotal_ff              <= rtotal_ff + 1'b1;
         end
      end
   end

   assign mask_agree  = (level_mask_ff == '0) == (rtotal_ff == '0);
   assign sleep_fits  = scount_ff <= CNT_W'(TASK_SLOTS);
   assign finish_done = rsp_valid_ff && (state_ff == pts_pkg::ST_IDLE);

   `PTS_ASSERT_ALWAYS(a_mask_total, clock, reset, mask_agree, "ready mask and total disagree")
   `PTS_ASSERT_ALWAYS(a_sleep_bound, clock, reset, sleep_fits, "delayed count over slots")
   `PTS_ASSERT_NEXT(a_finish_rsp, clock, reset, state_ff == pts_pkg::ST_FINISH, finish_done, "no result")

endmodule

`default_nettype wire

// File: hdl/priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// Fixed-priority task scheduler with per-level ready FIFOs and a delayed list.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one scheduler operation per transfer (req_valid, req_stall,
//   req_data). rsp_* returns exactly one result per operation, in order.
//   A transfer happens at a clock edge with valid high and stall low.
//   For add ready, query and rejected operations a request passes the front
//   register, the queue, decode and finish before rsp_valid rises. Remove
//   ready, add delayed and remove delayed also walk their list entry by
//   entry; a tick also steps through each woken task in turn.
//   The engine handles one item at a time and takes the next only after the
//   previous result has transferred. The front and a two-entry queue keep
//   taking requests meanwhile.
//   Reset (synchronous, active high) empties all lists and their counts at once.
//   If rsp_stall is held, the result waits in the output register, the
//   engine pauses, and req_stall rises once the queue and front are full.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_top #(
   parameter int PRIORITY_LEVELS = pts_pkg::PRIORITY_LEVELS_DEF,
   parameter int TASK_SLOTS      = pts_pkg::TASK_SLOTS_DEF,
   parameter int TICK_WIDTH      = pts_pkg::TICK_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pts_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pts_pkg::rsp_type      rsp_data
);

   logic             f_valid, f_stall, q_valid, q_pop;
   pts_pkg::cmd_type f_cmd, q_cmd;

   pts_front #(
      .PRIORITY_LEVELS(PRIORITY_LEVELS),
      .TASK_SLOTS     (TASK_SLOTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .cmd_valid(f_valid),
      .cmd_stall(f_stall),
      .cmd_data (f_cmd)
   );

   pts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_stall (f_stall),
      .in_cmd   (f_cmd),
      .out_valid(q_valid),
      .out_pop  (q_pop),
      .out_cmd  (q_cmd)
   );

   pts_engine #(
      .PRIORITY_LEVELS(PRIORITY_LEVELS),
      .TASK_SLOTS     (TASK_SLOTS),
      .TICK_WIDTH     (TICK_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_cmd    (q_cmd),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// File: bench/tb_priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler_top
// Self-checking bench for the priority task scheduler: a clocked driver sends
// operations from a pending queue, a scoreboard model of the ready FIFOs and
// the sorted delayed list predicts each result, and a clocked monitor compares
// every result field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_priority_task_scheduler_top;

   localparam int LEVELS    = 8;
   localparam int SLOTS     = 16;
   localparam int MAX_CYCLE = 400000;

   // action codes outside the defined set
   localparam logic [2:0] ACT_BAD_LO = 3'd6;
   localparam logic [2:0] ACT_BAD_HI = 3'd7;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pts_pkg::rsp_type rsp_data;

   priority_task_scheduler_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // scheduler state mirror
   logic [2:0]  sb_prio  [SLOTS];
   logic [1:0]  sb_where [SLOTS];
   logic [31:0] sb_wake  [SLOTS];
   int          fifo_q   [LEVELS][$];
   int          sleep_q  [$];

   pts_pkg::req_type pending_ops [$];
   pts_pkg::rsp_type expected_rsp [$];
   int      fail_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 36;
   int      recv_idle_pct = 45;
   bit      hold_send = 1'b0;
   logic    req_stall_s = 1'b1;

   // a is earlier than b when the wrapped difference is negative
   function automatic bit wake_is_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic pts_pkg::rsp_type schedule_op(pts_pkg::req_type r);
      pts_pkg::rsp_type res;
      int      t;
      int      pos;
      int      lvl;
      t   = int'(r.task_id);
      pos = 0;
      res = '0;
      case (r.action)
         pts_pkg::ACT_ADD_READY, pts_pkg::ACT_ADD_DELAY: begin
            if (sb_where[t] == pts_pkg::WHERE_NONE) begin
               sb_prio[t] = r.priority_req;
               if (r.action == pts_pkg::ACT_ADD_READY) begin
                  fifo_q[r.priority_req].push_back(t);
                  sb_where[t] = pts_pkg::WHERE_READY;
               end else begin
                  sb_wake[t] = r.tick_now + r.wait_ticks;
                  // equal wake times stay in insertion order
                  while (pos < sleep_q.size() &&
                         (wake_is_before(sb_wake[sleep_q[pos]], sb_wake[t]) ||
                          sb_wake[sleep_q[pos]] == sb_wake[t]))
                     pos++;
                  sleep_q.insert(pos, t);
                  sb_where[t] = pts_pkg::WHERE_DELAYED;
               end
            end else res.status = 1'b1;
         end
         pts_pkg::ACT_REM_READY: begin
            if (sb_where[t] == pts_pkg::WHERE_READY) begin
               lvl = int'(sb_prio[t]);
               for (int i = 0; i < fifo_q[lvl].size(); i++)
                  if (fifo_q[lvl][i] == t) pos = i;
               fifo_q[lvl].delete(pos);
               sb_where[t] = pts_pkg::WHERE_NONE;
            end else res.status = 1'b1;
         end
         pts_pkg::ACT_REM_DELAY: begin
            if (sb_where[t] == pts_pkg::WHERE_DELAYED) begin
               foreach (sleep_q[i]) if (sleep_q[i] == t) pos = i;
               sleep_q.delete(pos);
               sb_where[t] = pts_pkg::WHERE_NONE;
            end else res.status = 1'b1;
         end
         pts_pkg::ACT_TICK: begin
            while (sleep_q.size() > 0 &&
                   !wake_is_before(r.tick_now, sb_wake[sleep_q[0]])) begin
               t = sleep_q.pop_front();
               fifo_q[sb_prio[t]].push_back(t);
               sb_where[t] = pts_pkg::WHERE_READY;
               res.woken_count = res.woken_count + 5'd1;
            end
         end
         pts_pkg::ACT_QUERY: ;
         default: res.status = 1'b1;
      endcase
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
         if (fifo_q[lv].size() != 0) begin
            if (!res.next_valid) begin
               res.next_valid    = 1'b1;
               res.next_priority = 3'(lv);
               res.pick_task     = 4'(fifo_q[lv][0]);
            end
            res.ready_mask[lv] = 1'b1;
            res.ready_num      = res.ready_num + 5'(fifo_q[lv].size());
         end
      end
      res.sleep_num = 5'(sleep_q.size());
      res.preempt = res.next_valid && r.current_valid && res.pick_task != r.run_task
                    && res.next_priority > r.current_priority;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   task automatic queue_op(logic [2:0] act, int t, int p, logic [31:0] dly,
                           logic [31:0] now);
      pts_pkg::req_type r;
      r.action           = act;
      r.task_id          = 4'(t);
      r.priority_req     = 3'(p);
      r.wait_ticks       = dly;
      r.tick_now         = now;
      r.current_valid    = 1'($urandom_range(0, 1));
      r.run_task         = 4'($urandom_range(0, 15));
      r.current_priority = 3'($urandom_range(0, 7));
      pending_ops.push_back(r);
   endtask

   // driver: change inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall_s) begin
            if (!hold_send && pending_ops.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= pending_ops.pop_front();
               req_valid <= 1'b1;
            end else req_valid <= 1'b0;
         end else if (!req_valid) begin
            if (!hold_send && pending_ops.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= pending_ops.pop_front();
               req_valid <= 1'b1;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // capture the handshake at the rising edge for the driver's next decision
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_stall_s <= !(req_valid && !req_stall) ? 1'b1 : 1'b0;
      if (!reset && req_valid && !req_stall)
         expected_rsp.push_back(schedule_op(req_data));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            pts_pkg::rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_data.next_valid != e.next_valid)
               report_mismatch("next_valid", rsp_data.next_valid, e.next_valid);
            if (rsp_data.pick_task != e.pick_task)
               report_mismatch("pick_task", rsp_data.pick_task, e.pick_task);
            if (rsp_data.next_priority != e.next_priority)
               report_mismatch("next_priority", rsp_data.next_priority, e.next_priority);
            if (rsp_data.preempt != e.preempt)
               report_mismatch("preempt", rsp_data.preempt, e.preempt);
            if (rsp_data.ready_mask != e.ready_mask)
               report_mismatch("ready_mask", rsp_data.ready_mask, e.ready_mask);
            if (rsp_data.ready_num != e.ready_num)
               report_mismatch("ready_num", rsp_data.ready_num, e.ready_num);
            if (rsp_data.sleep_num != e.sleep_num)
               report_mismatch("sleep_num", rsp_data.sleep_num, e.sleep_num);
            if (rsp_data.woken_count != e.woken_count)
               report_mismatch("woken_count", rsp_data.woken_count, e.woken_count);
            if (rsp_data.status != e.status)
               report_mismatch("status", rsp_data.status, e.status);
         end
      end
      if (cycle_count > MAX_CYCLE) begin
         $display("timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // wait for the driver to hand off everything queued so far
   task automatic drain_sender();
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
   endtask

   task automatic wait_all_results();
      drain_sender();
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // one random operation; mostly well-formed, task ids not chosen from the mirrored state
   task automatic queue_random(ref logic [31:0] now);
      int roll;
      int t;
      roll = $urandom_range(0, 99);
      t    = $urandom_range(0, 15);
      if (roll < 8) begin
         queue_op(3'($urandom_range(0, 7)), t, $urandom_range(0, 7), $urandom, $urandom);
      end else if (roll < 28) begin
         queue_op(pts_pkg::ACT_ADD_READY, t, $urandom_range(0, 7), 0, now);
      end else if (roll < 40) begin
         queue_op(pts_pkg::ACT_REM_READY, t, 0, 0, now);
      end else if (roll < 62) begin
         queue_op(pts_pkg::ACT_ADD_DELAY, t, $urandom_range(0, 7),
                  ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12), now);
      end else if (roll < 70) begin
         queue_op(pts_pkg::ACT_REM_DELAY, t, 0, 0, now);
      end else if (roll < 93) begin
         now = now + $urandom_range(0, 4);
         queue_op(pts_pkg::ACT_TICK, t, 0, 0, now);
      end else begin
         queue_op(pts_pkg::ACT_QUERY, t, 0, 0, now);
      end
   endtask

   initial begin
      logic [31:0] now;
      foreach (sb_where[i]) sb_where[i] = pts_pkg::WHERE_NONE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every action, bad membership, wrap, ties, unknown codes
      queue_op(pts_pkg::ACT_QUERY, 0, 0, 0, 0);
      queue_op(pts_pkg::ACT_REM_READY, 3, 0, 0, 0);
      queue_op(pts_pkg::ACT_REM_DELAY, 3, 0, 0, 0);
      queue_op(pts_pkg::ACT_ADD_READY, 0, 0, 0, 0);
      queue_op(pts_pkg::ACT_ADD_READY, 15, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(pts_pkg::ACT_ADD_READY, 15, 3, 0, 0);
      queue_op(pts_pkg::ACT_ADD_READY, 5, 7, 0, 0);
      queue_op(pts_pkg::ACT_REM_READY, 15, 0, 0, 0);
      queue_op(pts_pkg::ACT_ADD_DELAY, 5, 2, 1, 0);
      queue_op(pts_pkg::ACT_ADD_DELAY, 8, 4, 32'h0000_0010, 32'hFFFF_FFF8);
      queue_op(pts_pkg::ACT_ADD_DELAY, 9, 1, 32'h0000_0010, 32'hFFFF_FFF8);
      queue_op(pts_pkg::ACT_ADD_DELAY, 10, 6, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_op(pts_pkg::ACT_ADD_DELAY, 11, 2, 0, 32'hFFFF_FFFF);
      queue_op(pts_pkg::ACT_ADD_DELAY, 12, 5, 32'hFFFF_FFFF, 0);
      queue_op(pts_pkg::ACT_REM_DELAY, 10, 0, 0, 0);
      queue_op(pts_pkg::ACT_TICK, 0, 0, 0, 32'h0000_0007);
      queue_op(pts_pkg::ACT_TICK, 0, 0, 0, 32'h0000_0008);
      queue_op(pts_pkg::ACT_TICK, 0, 0, 0, 32'h7FFF_FFFF);
      queue_op(ACT_BAD_LO, 15, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(ACT_BAD_HI, 0, 0, 0, 0);
      queue_op(pts_pkg::ACT_REM_DELAY, 12, 0, 0, 0);
      queue_op(pts_pkg::ACT_REM_READY, 0, 0, 0, 0);
      wait_all_results();

      // pause the sender with an operation pending, then release it and wait for every result
      hold_send = 1'b1;
      queue_op(pts_pkg::ACT_QUERY, 1, 1, 0, 0);
      repeat (20) @(posedge clock);
      hold_send = 1'b0;
      wait_all_results();

      now = $urandom;
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 45;
            recv_idle_pct = 36;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 185; n++) begin
            queue_random(now);
            if (pending_ops.size() > 8) drain_sender();
         end
         wait_all_results();
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
